// File: sv/graph_dfs_depth_query_defines.svh
// Assertion macros used by the design file graph_dfs_depth_query.sv.
`ifndef GRAPH_DFS_DEPTH_QUERY_DEFINES_SVH
`define GRAPH_DFS_DEPTH_QUERY_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check that is skipped while reset is high.
`define GDFS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds across reset.
`define GDFS_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GDFS_ASSERT(label, clk, rst, prop, msg)
`define GDFS_ASSERT_NR(label, clk, prop, msg)
`endif

`endif

// File: sv/gdfs_pkg.sv
package gdfs_pkg;

  // Graph size and field widths.
  localparam int NUM_VERTICES = 64;
  localparam int VTX_W        = 6;
  localparam int DIST_W       = 6;
  localparam int VIDX_W       = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
  localparam int LVL_W        = $clog2(NUM_VERTICES + 1);

  // Request codes.
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef logic [VTX_W-1:0]        vtx_t;
  typedef logic [VIDX_W-1:0]       vidx_t;
  typedef logic [NUM_VERTICES-1:0] row_t;
  typedef logic [LVL_W-1:0]        lvl_t;
  typedef logic [DIST_W-1:0]       dist_t;

  typedef struct packed {
    logic req_type;
    vtx_t vertex_a;
    vtx_t vertex_b;
  } gdfs_req_t;

  typedef struct packed {
    dist_t distance;
    logic  reached;
  } gdfs_rsp_t;

  // True when the vertex number names a vertex of the graph.
  function automatic logic in_range(vtx_t v);
    return ({1'b0, v} < (VTX_W + 1)'(NUM_VERTICES));
  endfunction

  // Priority encoder: index of the lowest set bit (zero when none is set).
  function automatic vidx_t lowest_set(row_t v);
    vidx_t idx;
    idx = '0;
    for (int i = NUM_VERTICES - 1; i >= 0; i--) begin
      if (v[i]) idx = VIDX_W'(i);
    end
    return idx;
  endfunction

endpackage

// File: sv/graph_dfs_depth_query.sv
// Channel  | Direction | Handshake             | Word
// ---------+-----------+-----------------------+--------------------------------
// req      | in        | req_valid / req_ready | req_type, vertex_a, vertex_b
// rsp      | out       | rsp_valid / rsp_ready | distance, reached (queries only)
//
// An add with both vertices in range does a read-modify-write of each of the two
// adjacency rows through the single adjacency read port; other adds are dropped.
// A query places the root, pushes each newly reached vertex and pops when the top
// has no unvisited neighbor, reading the new top from the stack but for the last
// pop, and then loads the result. req_ready is high only while the sequencer
// is idle. A finished response waits in the output register while rsp_ready is
// low; adds and the next search go on, but that search holds in ST_RESULT. Reset
// is synchronous and clears the graph and depth store at once by per-row valid bits.
`include "graph_dfs_depth_query_defines.svh"

module graph_dfs_depth_query (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  gdfs_pkg::gdfs_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output gdfs_pkg::gdfs_rsp_t rsp
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_ADD_WR_A = 8'b0000_0010,
    ST_ADD_RD_B = 8'b0000_0100,
    ST_ADD_WR_B = 8'b0000_1000,
    ST_Q_START  = 8'b0001_0000,
    ST_SCAN     = 8'b0010_0000,
    ST_POP      = 8'b0100_0000,
    ST_RESULT   = 8'b1000_0000
  } state_t;

  localparam gdfs_pkg::row_t ROW_ONE = gdfs_pkg::row_t'(1);

  state_t              state, state_next;
  gdfs_pkg::gdfs_req_t cur;
  gdfs_pkg::row_t      visited, visited_next;
  gdfs_pkg::lvl_t      level, level_next;
  gdfs_pkg::lvl_t      level_m2;

  // Adjacency memory with one valid bit per row.
  gdfs_pkg::row_t      adj_mem [gdfs_pkg::NUM_VERTICES];
  gdfs_pkg::row_t      adj_valid;
  gdfs_pkg::row_t      adj_rd;
  logic                adj_rd_ok;
  gdfs_pkg::vidx_t     adj_addr;
  logic                adj_we;
  gdfs_pkg::vidx_t     adj_waddr;
  gdfs_pkg::row_t      adj_wdata;

  // Depth store with one valid bit per entry.
  gdfs_pkg::dist_t     dep_mem [gdfs_pkg::NUM_VERTICES];
  gdfs_pkg::row_t      dep_valid;
  gdfs_pkg::dist_t     dep_rd;
  logic                dep_rd_ok;
  logic                dep_we;
  gdfs_pkg::vidx_t     dep_waddr;
  gdfs_pkg::dist_t     dep_wdata;

  // Search stack.
  gdfs_pkg::vidx_t     stk_mem [gdfs_pkg::NUM_VERTICES];
  gdfs_pkg::vidx_t     stk_rd;
  gdfs_pkg::vidx_t     stk_raddr;
  logic                stk_we;
  gdfs_pkg::vidx_t     stk_waddr;
  gdfs_pkg::vidx_t     stk_wdata;

  gdfs_pkg::vidx_t     a_idx, b_idx, n_idx;
  logic                a_ok, b_ok;
  gdfs_pkg::row_t      row_cur, cand;
  logic                rsp_load;

  assign req_ready = (state == ST_IDLE);

  // Decoded operands of the word being worked on.
  assign a_idx   = cur.vertex_a[gdfs_pkg::VIDX_W-1:0];
  assign b_idx   = cur.vertex_b[gdfs_pkg::VIDX_W-1:0];
  assign a_ok    = gdfs_pkg::in_range(cur.vertex_a);
  assign b_ok    = gdfs_pkg::in_range(cur.vertex_b);

  // Shared scan unit: unvisited neighbors of the top vertex and the lowest one.
  assign row_cur = adj_rd_ok ? adj_rd : '0;
  assign cand    = row_cur & ~visited;
  assign n_idx   = gdfs_pkg::lowest_set(cand);

  // Stack slot that becomes the top after a pop.
  assign level_m2 = level - gdfs_pkg::lvl_t'(2);

  assign rsp_load = (state == ST_RESULT) && (!rsp_valid || rsp_ready);

  // Sequencer.
  always_comb begin
    state_next   = state;
    visited_next = visited;
    level_next   = level;
    adj_addr     = a_idx;
    adj_we       = 1'b0;
    adj_waddr    = a_idx;
    adj_wdata    = row_cur | (ROW_ONE << b_idx);
    dep_we       = 1'b0;
    dep_waddr    = n_idx;
    dep_wdata    = gdfs_pkg::dist_t'(level);
    stk_we       = 1'b0;
    stk_waddr    = level[gdfs_pkg::VIDX_W-1:0];
    stk_wdata    = n_idx;
    stk_raddr    = level_m2[gdfs_pkg::VIDX_W-1:0];
    unique case (state)
      ST_IDLE: begin
        adj_addr = req.vertex_a[gdfs_pkg::VIDX_W-1:0];
        if (req_valid) begin
          if (req.req_type == gdfs_pkg::REQ_QUERY) begin
            state_next = ST_Q_START;
          end else if (gdfs_pkg::in_range(req.vertex_a) &&
                       gdfs_pkg::in_range(req.vertex_b)) begin
            state_next = ST_ADD_WR_A;
          end
        end
      end
      ST_ADD_WR_A: begin
        adj_we     = 1'b1;
        state_next = ST_ADD_RD_B;
      end
      ST_ADD_RD_B: begin
        adj_addr   = b_idx;
        state_next = ST_ADD_WR_B;
      end
      ST_ADD_WR_B: begin
        adj_we     = 1'b1;
        adj_waddr  = b_idx;
        adj_wdata  = row_cur | (ROW_ONE << a_idx);
        state_next = ST_IDLE;
      end
      ST_Q_START: begin
        // Root goes on the stack at depth zero; its row is fetched.
        visited_next = '0;
        if (a_ok) begin
          visited_next = ROW_ONE << a_idx;
          dep_we       = 1'b1;
          dep_waddr    = a_idx;
          dep_wdata    = '0;
          stk_we       = 1'b1;
          stk_waddr    = '0;
          stk_wdata    = a_idx;
          level_next   = gdfs_pkg::lvl_t'(1);
          state_next   = ST_SCAN;
        end else begin
          state_next   = ST_RESULT;
        end
      end
      ST_SCAN: begin
        if (cand != '0) begin
          // Push the lowest unvisited neighbor and fetch its row.
          visited_next = visited | (ROW_ONE << n_idx);
          dep_we       = 1'b1;
          stk_we       = 1'b1;
          level_next   = level + gdfs_pkg::lvl_t'(1);
          adj_addr     = n_idx;
        end else begin
          // Pop; the new top comes from the stack next cycle.
          level_next   = level - gdfs_pkg::lvl_t'(1);
          state_next   = (level == gdfs_pkg::lvl_t'(1)) ? ST_RESULT : ST_POP;
        end
      end
      ST_POP: begin
        adj_addr   = stk_rd;
        state_next = ST_SCAN;
      end
      ST_RESULT: begin
        if (rsp_load) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      level     <= '0;
      visited   <= '0;
      adj_valid <= '0;
      dep_valid <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      level   <= level_next;
      visited <= visited_next;
      if (adj_we) adj_valid[adj_waddr] <= 1'b1;
      if (dep_we) dep_valid[dep_waddr] <= 1'b1;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Captured request word and response word.
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) cur <= req;
    if (rsp_load) begin
      rsp.distance <= (b_ok && dep_rd_ok) ? dep_rd : '0;
      rsp.reached  <= b_ok && visited[b_idx];
    end
  end

  // Memories with registered reads.
  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
    adj_rd    <= adj_mem[adj_addr];
    adj_rd_ok <= adj_valid[adj_addr];
    if (dep_we) dep_mem[dep_waddr] <= dep_wdata;
    dep_rd    <= dep_mem[b_idx];
    dep_rd_ok <= dep_valid[b_idx];
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_rd    <= stk_mem[stk_raddr];
  end

  // Checks on the sequencer.
  `GDFS_ASSERT_NR(a_reset_idle, clk, rst |=> (state == ST_IDLE && !rsp_valid && level == '0), "reset did not return to idle")
  `GDFS_ASSERT(a_scan_level, clk, rst, (state == ST_SCAN) |-> (level != '0), "scan with empty stack")
  `GDFS_ASSERT(a_idle_level, clk, rst, (state == ST_IDLE) |-> (level == '0), "stack not empty at idle")
  `GDFS_ASSERT(a_pop_scan, clk, rst, (state == ST_POP) |=> (state == ST_SCAN), "pop not followed by scan")
  `GDFS_ASSERT(a_result_out, clk, rst, rsp_load |=> rsp_valid, "finished query gave no word")

endmodule

// File: tb/tb_graph_dfs_depth_query.sv
module tb_graph_dfs_depth_query;
  timeunit 1ns;
  timeprecision 1ps;

  import gdfs_pkg::*;

  localparam int RUN_LIMIT = 1000000;
  localparam int TAIL_WAIT = 400;

  // Shadow of the graph and depth store that predicts each query answer.
  class dfs_depth_book;
    row_t      links [NUM_VERTICES];
    dist_t     depths [NUM_VERTICES];
    gdfs_rsp_t owed [$];
    int unsigned faults;

    function new();
      foreach (links[i]) begin
        links[i]  = '0;
        depths[i] = '0;
      end
      faults = 0;
    endfunction

    // Walk the graph depth first from root, always taking the lowest unvisited
    // neighbor, and record the depth of every vertex reached.
    function gdfs_rsp_t search_depth(vtx_t root, vtx_t target);
      row_t      seen;
      row_t      open;
      vtx_t      trail [NUM_VERTICES];
      int        level;
      int        nxt;
      gdfs_rsp_t ans;
      seen  = '0;
      level = 0;
      if (int'(root) < NUM_VERTICES) begin
        seen[root]   = 1'b1;
        depths[root] = '0;
        trail[0]     = root;
        level        = 1;
      end
      while (level > 0) begin
        open = links[trail[level-1]] & ~seen;
        if (open == '0 || level >= NUM_VERTICES) begin
          level--;
        end else begin
          nxt = 0;
          while (!open[nxt]) nxt++;
          seen[nxt]    = 1'b1;
          depths[nxt]  = dist_t'(level);
          trail[level] = vtx_t'(nxt);
          level++;
        end
      end
      // A target outside the graph answers zero and not reached.
      ans = '0;
      if (int'(target) < NUM_VERTICES) begin
        ans.distance = depths[target];
        ans.reached  = seen[target];
      end
      return ans;
    endfunction

    // An add updates the shadow graph; a query queues its predicted answer.
    function void note_request(gdfs_req_t w);
      if (w.req_type == REQ_ADD) begin
        if (int'(w.vertex_a) < NUM_VERTICES && int'(w.vertex_b) < NUM_VERTICES) begin
          links[w.vertex_a][w.vertex_b] = 1'b1;
          links[w.vertex_b][w.vertex_a] = 1'b1;
        end
      end else begin
        owed.push_back(search_depth(w.vertex_a, w.vertex_b));
      end
    endfunction

    // Compare a response word with the oldest predicted answer.
    function void check_answer(gdfs_rsp_t got);
      gdfs_rsp_t want;
      if (owed.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("%0t: unexpected response word: distance %0d reached %0b",
                   $time, got.distance, got.reached);
        return;
      end
      want = owed.pop_front();
      if (got.distance !== want.distance || got.reached !== want.reached) begin
        faults++;
        if (faults <= 10)
          $display("%0t: response mismatch: expected distance %0d reached %0b, got distance %0d reached %0b",
                   $time, want.distance, want.reached, got.distance, got.reached);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_ready;
  gdfs_req_t req;
  logic      rsp_valid;
  logic      rsp_ready;
  gdfs_rsp_t rsp;

  dfs_depth_book book = new();
  bit            quiet_tail = 1'b0;
  int            steady_left = 0;
  int unsigned   cycle_count = 0;

  graph_dfs_depth_query i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("[graph_dfs_depth_query] ERROR");
      $finish;
    end
  end

  // Offer one request word, with an occasional random gap ahead of it, and
  // hand it to the scoreboard once the block takes it.
  task automatic send_word(input logic kind, input vtx_t a, input vtx_t b);
    gdfs_req_t w;
    int        gap;
    w.req_type = kind;
    w.vertex_a = a;
    w.vertex_b = b;
    if (!quiet_tail) begin
      if (steady_left > 0) begin
        steady_left--;
      end else if ($urandom_range(0, 9) == 0) begin
        steady_left = $urandom_range(10, 40);
      end else if ($urandom_range(0, 2) == 0) begin
        gap = $urandom_range(1, 19);
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    book.note_request(w);
  endtask

  task automatic add_link(input vtx_t a, input vtx_t b);
    send_word(REQ_ADD, a, b);
  endtask

  task automatic ask_depth(input vtx_t a, input vtx_t b);
    send_word(REQ_QUERY, a, b);
  endtask

  function automatic vtx_t any_vertex();
    return vtx_t'($urandom_range(0, NUM_VERTICES - 1));
  endfunction

  // Response side: random stalls, one long hold-off, and none at the end.
  initial begin : answer_drain
    int low_left;
    int high_left;
    int words_taken;
    bit squeezed;
    low_left    = 0;
    high_left   = 0;
    words_taken = 0;
    squeezed    = 1'b0;
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) begin
        book.check_answer(rsp);
        words_taken++;
      end
      // Hold off long enough that the block fills up and refuses requests.
      if (!squeezed && words_taken == 30) begin
        squeezed  = 1'b1;
        low_left  = 3000;
        high_left = 0;
      end else if (quiet_tail) begin
        low_left  = 0;
        high_left = 1;
      end else if (low_left == 0 && high_left == 0) begin
        if ($urandom_range(0, 2) == 0)
          low_left = $urandom_range(1, 19);
        else if ($urandom_range(0, 9) == 0)
          high_left = $urandom_range(100, 400);
        else
          high_left = $urandom_range(1, 30);
      end
      if (low_left > 0) begin
        low_left--;
        rsp_ready <= 1'b0;
      end else begin
        if (high_left > 0) high_left--;
        rsp_ready <= 1'b1;
      end
    end
  end

  // Request side and end of run.
  initial begin : request_feed
    vtx_t route [NUM_VERTICES];
    int   order [NUM_VERTICES-1];
    int   j;
    int   held;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words: isolated start, unreached target with a stale depth,
    // self-loop, duplicate edge in both orders, and the extreme vertices.
    ask_depth(0, 0);
    ask_depth(63, 5);
    add_link(63, 63);
    ask_depth(63, 63);
    add_link(0, 1);
    add_link(1, 0);
    add_link(1, 2);
    add_link(2, 63);
    ask_depth(0, 63);
    ask_depth(63, 0);
    ask_depth(5, 63);
    ask_depth(0, 5);
    add_link(62, 61);
    ask_depth(61, 62);
    ask_depth(0, 62);
    ask_depth(2, 1);
    ask_depth(42, 42);

    // Build one path through every vertex, extending the directed chain, in
    // random edge order with queries between, so early queries see a split
    // graph and later ones reach full depth.
    for (int k = 0; k < NUM_VERTICES; k++)
      route[k] = (k < 3) ? vtx_t'(k) : (k == 3) ? vtx_t'(NUM_VERTICES - 1) : vtx_t'(k - 1);
    for (int k = 0; k < NUM_VERTICES - 1; k++) order[k] = k;
    for (int k = NUM_VERTICES - 2; k > 0; k--) begin
      j        = $urandom_range(0, k);
      held     = order[k];
      order[k] = order[j];
      order[j] = held;
    end
    for (int k = 0; k < NUM_VERTICES - 1; k++) begin
      add_link(route[order[k]], route[order[k] + 1]);
      repeat ($urandom_range(1, 3)) ask_depth(any_vertex(), any_vertex());
    end

    // Sweep the finished path end to end and from its head.
    ask_depth(route[0], route[NUM_VERTICES-1]);
    ask_depth(route[NUM_VERTICES-1], route[0]);
    repeat (20) ask_depth(route[0], any_vertex());

    // Random mix of adds and queries over the growing graph.
    for (int k = 0; k < 650; k++) begin
      if (k >= 550) quiet_tail = 1'b1;
      if ($urandom_range(0, 9) < 3)
        add_link(any_vertex(), any_vertex());
      else
        ask_depth(any_vertex(), any_vertex());
    end
    req_valid <= 1'b0;

    // Drain the outstanding answers, then watch for strays.
    while (book.owed.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (book.faults == 0)
      $display("[graph_dfs_depth_query] OK");
    else
      $display("[graph_dfs_depth_query] ERROR");
    $finish;
  end

endmodule

// File: graph_dfs_depth_query.f
+incdir+sv
sv/gdfs_pkg.sv
sv/graph_dfs_depth_query.sv
tb/tb_graph_dfs_depth_query.sv
